// ----- hw/rtl/etrm_pkg.sv -----
// shared types, constants and helper functions for the euler to rotation matrix block
package etrm_pkg;

	localparam int ANGLE_W         = 16;
	localparam int Q14_W           = 16;
	localparam int Q_FRAC          = 14;
	localparam int CORDIC_W        = 32;
	localparam int Z_SHIFT         = CORDIC_W - ANGLE_W;
	localparam int ROUND_SHIFT     = 16;
	localparam int CORDIC_ITERS    = 24;
	localparam int ITERS_PER_STAGE = 3;
	localparam int CORDIC_STAGES   = CORDIC_ITERS / ITERS_PER_STAGE;
	localparam int ITER_IDX_W      = 5;
	localparam int LANES           = 3;
	localparam int WIDE_W          = 48;

	// lane order: bank (x), pitch (y), heading (z)
	localparam int LANE_X = 0;
	localparam int LANE_Y = 1;
	localparam int LANE_Z = 2;

	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN  = 32'sd652032874;
	localparam logic signed [CORDIC_W-1:0] TRIG_RND     = 32'sd32768;
	localparam logic signed [Q14_W-1:0]    ONE_Q14      = 16'sd16384;
	localparam logic signed [ANGLE_W:0]    QUARTER_TURN = 17'sd16384;
	localparam logic signed [ANGLE_W:0]    HALF_TURN    = 17'sd32768;

	typedef logic signed [Q14_W-1:0] q14_t;

	typedef struct packed {
		q14_t cos_v;
		q14_t sin_v;
	} sincos_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] bank_angle;
		logic signed [ANGLE_W-1:0] pitch_angle;
		logic signed [ANGLE_W-1:0] heading_angle;
	} euler_in_t;

	typedef struct packed {
		q14_t m00;
		q14_t m01;
		q14_t m02;
		q14_t m10;
		q14_t m11;
		q14_t m12;
		q14_t m20;
		q14_t m21;
		q14_t m22;
	} euler_out_t;

	// arctangent of 2^-i, full circle is 2^32
	function automatic logic signed [CORDIC_W-1:0] atan_entry(input logic [ITER_IDX_W-1:0] idx);
		logic signed [CORDIC_W-1:0] v;
		case (idx)
			5'd0:    v = 32'sh20000000;
			5'd1:    v = 32'sh12E4051E;
			5'd2:    v = 32'sh09FB385B;
			5'd3:    v = 32'sh051111D4;
			5'd4:    v = 32'sh028B0D43;
			5'd5:    v = 32'sh0145D7E1;
			5'd6:    v = 32'sh00A2F61E;
			5'd7:    v = 32'sh00517C55;
			5'd8:    v = 32'sh0028BE53;
			5'd9:    v = 32'sh00145F2F;
			5'd10:   v = 32'sh000A2F98;
			5'd11:   v = 32'sh000517CC;
			5'd12:   v = 32'sh00028BE6;
			5'd13:   v = 32'sh000145F3;
			5'd14:   v = 32'sh0000A2FA;
			5'd15:   v = 32'sh0000517D;
			5'd16:   v = 32'sh000028BE;
			5'd17:   v = 32'sh0000145F;
			5'd18:   v = 32'sh00000A30;
			5'd19:   v = 32'sh00000518;
			5'd20:   v = 32'sh0000028C;
			5'd21:   v = 32'sh00000146;
			5'd22:   v = 32'sh000000A3;
			5'd23:   v = 32'sh00000051;
			default: v = '0;
		endcase
		return v;
	endfunction

	// clamp to plus or minus one in q2.14
	function automatic q14_t sat_unit(input logic signed [WIDE_W-1:0] v);
		q14_t r;
		if (v > WIDE_W'(ONE_Q14)) begin
			r = ONE_Q14;
		end else if (v < -WIDE_W'(ONE_Q14)) begin
			r = -ONE_Q14;
		end else begin
			r = v[Q14_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/etrm_sincos.sv -----
// pipelined cordic sine and cosine for the three euler angles
module etrm_sincos (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    en,
	input  logic                                    in_valid,
	input  etrm_pkg::euler_in_t                     angles,
	output logic                                    out_valid,
	output etrm_pkg::sincos_t [etrm_pkg::LANES-1:0] trig
);
	import etrm_pkg::*;

	logic signed [ANGLE_W-1:0]  ang   [LANES];

	// index 0 is the fold stage, 1.. are the cordic stages
	logic signed [CORDIC_W-1:0] x_s    [LANES][CORDIC_STAGES+1];
	logic signed [CORDIC_W-1:0] y_s    [LANES][CORDIC_STAGES+1];
	logic signed [CORDIC_W-1:0] z_s    [LANES][CORDIC_STAGES+1];
	logic                       neg_s  [LANES][CORDIC_STAGES+1];
	logic signed [CORDIC_W-1:0] x_nx   [LANES][CORDIC_STAGES+1];
	logic signed [CORDIC_W-1:0] y_nx   [LANES][CORDIC_STAGES+1];
	logic signed [CORDIC_W-1:0] z_nx   [LANES][CORDIC_STAGES+1];
	logic                       neg_nx [LANES][CORDIC_STAGES+1];

	sincos_t [LANES-1:0]        trig_nx;
	sincos_t [LANES-1:0]        trig_s10;
	logic [CORDIC_STAGES+1:0]   valid_s;

	assign ang[LANE_X] = angles.bank_angle;
	assign ang[LANE_Y] = angles.pitch_angle;
	assign ang[LANE_Z] = angles.heading_angle;

	always_comb begin
		logic signed [ANGLE_W:0]    ext;
		logic signed [CORDIC_W-1:0] xt;
		logic signed [CORDIC_W-1:0] yt;
		logic signed [CORDIC_W-1:0] zt;
		logic signed [CORDIC_W-1:0] dx;
		logic signed [CORDIC_W-1:0] dy;
		logic signed [CORDIC_W-1:0] xr;
		logic signed [CORDIC_W-1:0] yr;
		logic [ITER_IDX_W-1:0]      it;
		for (int l = 0; l < LANES; l++) begin
			// fold into the quarter turn range, flip sign afterwards
			ext = {ang[l][ANGLE_W-1], ang[l]};
			if (ext > QUARTER_TURN) begin
				ext = ext - HALF_TURN;
				neg_nx[l][0] = 1'b1;
			end else if (ext < -QUARTER_TURN) begin
				ext = ext + HALF_TURN;
				neg_nx[l][0] = 1'b1;
			end else begin
				neg_nx[l][0] = 1'b0;
			end
			x_nx[l][0] = CORDIC_GAIN;
			y_nx[l][0] = '0;
			z_nx[l][0] = {ext[ANGLE_W-1:0], {Z_SHIFT{1'b0}}};

			for (int k = 1; k <= CORDIC_STAGES; k++) begin
				xt = x_s[l][k-1];
				yt = y_s[l][k-1];
				zt = z_s[l][k-1];
				for (int j = 0; j < ITERS_PER_STAGE; j++) begin
					it = ITER_IDX_W'((k - 1) * ITERS_PER_STAGE + j);
					dx = yt >>> it;
					dy = xt >>> it;
					if (!zt[CORDIC_W-1]) begin
						xt = xt - dx;
						yt = yt + dy;
						zt = zt - atan_entry(it);
					end else begin
						xt = xt + dx;
						yt = yt - dy;
						zt = zt + atan_entry(it);
					end
				end
				x_nx[l][k]   = xt;
				y_nx[l][k]   = yt;
				z_nx[l][k]   = zt;
				neg_nx[l][k] = neg_s[l][k-1];
			end

			// back to q2.14, round half up
			xr = neg_s[l][CORDIC_STAGES] ? -x_s[l][CORDIC_STAGES] : x_s[l][CORDIC_STAGES];
			yr = neg_s[l][CORDIC_STAGES] ? -y_s[l][CORDIC_STAGES] : y_s[l][CORDIC_STAGES];
			xr = (xr + TRIG_RND) >>> ROUND_SHIFT;
			yr = (yr + TRIG_RND) >>> ROUND_SHIFT;
			trig_nx[l].cos_v = sat_unit(WIDE_W'(xr));
			trig_nx[l].sin_v = sat_unit(WIDE_W'(yr));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s      <= x_nx;
			y_s      <= y_nx;
			z_s      <= z_nx;
			neg_s    <= neg_nx;
			trig_s10 <= trig_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[CORDIC_STAGES:0], in_valid};
		end
	end

	assign out_valid = valid_s[CORDIC_STAGES+1];
	assign trig      = trig_s10;

endmodule

// ----- hw/rtl/etrm_matmul.sv -----
// three stage fixed point product x * (y * z) with rounding and saturation
module etrm_matmul (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    en,
	input  logic                                    in_valid,
	input  etrm_pkg::sincos_t [etrm_pkg::LANES-1:0] trig,
	output logic                                    out_valid,
	output etrm_pkg::euler_out_t                    matrix
);
	import etrm_pkg::*;

	localparam int YZ_W    = 2 * Q14_W - 2;
	localparam int PROD_W  = Q14_W + YZ_W;
	localparam int SUM_W   = PROD_W + 1;
	localparam int R_SHIFT = 2 * Q_FRAC;
	localparam logic signed [WIDE_W-1:0] R_RND = WIDE_W'(1) <<< (R_SHIFT - 1);

	q14_t                    cx, sx, cy, sy, cz, sz;
	logic signed [YZ_W-1:0]  yz_nx  [3][3];
	logic signed [YZ_W-1:0]  yz_s1  [3][3];
	q14_t                    cx_s1, sx_s1;
	logic signed [YZ_W-1:0]  row0_s2 [3];
	logic signed [PROD_W-1:0] p1a_s2 [3];
	logic signed [PROD_W-1:0] p1b_s2 [3];
	logic signed [PROD_W-1:0] p2a_s2 [3];
	logic signed [PROD_W-1:0] p2b_s2 [3];
	q14_t                    r_nx   [3][3];
	euler_out_t              matrix_s3;
	logic [2:0]              valid_s;

	function automatic q14_t round_q42(input logic signed [SUM_W-1:0] v);
		logic signed [WIDE_W-1:0] w;
		w = (WIDE_W'(v) + R_RND) >>> R_SHIFT;
		return sat_unit(w);
	endfunction

	assign cx = trig[LANE_X].cos_v;
	assign sx = trig[LANE_X].sin_v;
	assign cy = trig[LANE_Y].cos_v;
	assign sy = trig[LANE_Y].sin_v;
	assign cz = trig[LANE_Z].cos_v;
	assign sz = trig[LANE_Z].sin_v;

	// y * z in q28
	always_comb begin
		yz_nx[0][0] = YZ_W'(cy) * YZ_W'(cz);
		yz_nx[0][1] = YZ_W'(cy) * YZ_W'(sz);
		yz_nx[0][2] = -(YZ_W'(sy) <<< Q_FRAC);
		yz_nx[1][0] = -(YZ_W'(sz) <<< Q_FRAC);
		yz_nx[1][1] = YZ_W'(cz) <<< Q_FRAC;
		yz_nx[1][2] = '0;
		yz_nx[2][0] = YZ_W'(sy) * YZ_W'(cz);
		yz_nx[2][1] = YZ_W'(sy) * YZ_W'(sz);
		yz_nx[2][2] = YZ_W'(cy) <<< Q_FRAC;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yz_s1 <= yz_nx;
			cx_s1 <= cx;
			sx_s1 <= sx;
			for (int j = 0; j < 3; j++) begin
				row0_s2[j] <= yz_s1[0][j];
				p1a_s2[j]  <= PROD_W'(cx_s1) * PROD_W'(yz_s1[1][j]);
				p1b_s2[j]  <= PROD_W'(sx_s1) * PROD_W'(yz_s1[2][j]);
				p2a_s2[j]  <= PROD_W'(sx_s1) * PROD_W'(yz_s1[1][j]);
				p2b_s2[j]  <= PROD_W'(cx_s1) * PROD_W'(yz_s1[2][j]);
			end
			matrix_s3 <= '{m00: r_nx[0][0], m01: r_nx[0][1], m02: r_nx[0][2],
			               m10: r_nx[1][0], m11: r_nx[1][1], m12: r_nx[1][2],
			               m20: r_nx[2][0], m21: r_nx[2][1], m22: r_nx[2][2]};
		end
	end

	// rows of x * (y * z) in q42, then back to q2.14
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			r_nx[0][j] = round_q42(SUM_W'(row0_s2[j]) <<< Q_FRAC);
			r_nx[1][j] = round_q42(SUM_W'(p1a_s2[j]) + SUM_W'(p1b_s2[j]));
			r_nx[2][j] = round_q42(SUM_W'(p2b_s2[j]) - SUM_W'(p2a_s2[j]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[1:0], in_valid};
		end
	end

	assign out_valid = valid_s[2];
	assign matrix    = matrix_s3;

endmodule

// ----- hw/rtl/euler_to_rotation_matrix.sv -----
// top level: euler angles in, zyx rotation matrix out
// an accepted item goes through the cordic stages, then the product stages, to its matrix
// one item per cycle unless stalled; the cordic is fully pipelined (3 iterations per stage)
// a stall on the matrix side freezes every stage at once; bubbles in flight are kept in place
// reset clears only the valid bits of each stage; data registers are not reset
module euler_to_rotation_matrix (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 angle_valid,
	output logic                 angle_stall,
	input  etrm_pkg::euler_in_t  angles,
	output logic                 matrix_valid,
	input  logic                 matrix_stall,
	output etrm_pkg::euler_out_t matrix
);
	import etrm_pkg::*;

	// the whole pipe moves unless the result at the output is held back
	logic                en;
	logic                trig_valid;
	sincos_t [LANES-1:0] trig;

	assign en          = !(matrix_valid && matrix_stall);
	assign angle_stall = !en;

	// cosine and sine for bank, pitch and heading in parallel lanes
	etrm_sincos u_sincos (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (angle_valid),
		.angles    (angles),
		.out_valid (trig_valid),
		.trig      (trig)
	);

	// y * z, then x * (y * z), rounded and clamped to unit range
	etrm_matmul u_matmul (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (trig_valid),
		.trig      (trig),
		.out_valid (matrix_valid),
		.matrix    (matrix)
	);

	// a held output must freeze the internal stages too
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(trig) && $stable(trig_valid))
		else $error("sincos stage moved during a stall");

	// every valid sine and cosine is within unit range
	for (genvar l = 0; l < LANES; l++) begin : g_trig_chk
		a_trig_range: assert property (@(posedge clk) disable iff (!arst_n)
			trig_valid |-> (trig[l].cos_v <= ONE_Q14) && (trig[l].cos_v >= -ONE_Q14) &&
			               (trig[l].sin_v <= ONE_Q14) && (trig[l].sin_v >= -ONE_Q14))
			else $error("sine or cosine out of range");
	end

	// every valid matrix entry is within unit range
	a_matrix_range: assert property (@(posedge clk) disable iff (!arst_n)
		matrix_valid |->
			(matrix.m00 <= ONE_Q14) && (matrix.m00 >= -ONE_Q14) &&
			(matrix.m01 <= ONE_Q14) && (matrix.m01 >= -ONE_Q14) &&
			(matrix.m02 <= ONE_Q14) && (matrix.m02 >= -ONE_Q14) &&
			(matrix.m10 <= ONE_Q14) && (matrix.m10 >= -ONE_Q14) &&
			(matrix.m11 <= ONE_Q14) && (matrix.m11 >= -ONE_Q14) &&
			(matrix.m12 <= ONE_Q14) && (matrix.m12 >= -ONE_Q14) &&
			(matrix.m20 <= ONE_Q14) && (matrix.m20 >= -ONE_Q14) &&
			(matrix.m21 <= ONE_Q14) && (matrix.m21 >= -ONE_Q14) &&
			(matrix.m22 <= ONE_Q14) && (matrix.m22 >= -ONE_Q14))
		else $error("matrix entry out of range");

	// first row entry m02 is the negated pitch sine, carried through the product stages
	a_m02_sine: assert property (@(posedge clk) disable iff (!arst_n)
		trig_valid && en ##1 en ##1 en |=> matrix_valid &&
			(matrix.m02 == -$past(trig[LANE_Y].sin_v, 3)))
		else $error("m02 does not follow pitch sine");

endmodule
